### rtl/core/ocbe_pkg.sv
// Shared constants, control-word type and microcode table for the ohmmeter band encoder.
package ocbe_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int MAX_SAMPLES = 1023;
  localparam int COUNT_W     = 10;
  localparam int SUM_W       = SAMPLE_BITS + COUNT_W;
  localparam int KR_W        = 20;
  localparam int FS_W        = 12;
  localparam int NUM_W       = KR_W + SUM_W;
  localparam int RES_W       = 31;
  localparam int NUM_HI_W    = NUM_W - RES_W;
  localparam int AVG_W       = 12;
  localparam int DIG_W       = 4;
  localparam int MULT_W      = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_W       = 20;
  localparam int STEP_W      = 4;
  localparam int DCNT_W      = 5;
  localparam int TEN_W       = 7;
  localparam int P10_W       = NUM_W + 4;

  // quotient bits produced by each divide pass
  localparam logic [DCNT_W-1:0] AVG_STEPS = DCNT_W'(AVG_W);
  localparam logic [DCNT_W-1:0] RES_STEPS = DCNT_W'(RES_W);
  localparam logic [DCNT_W-1:0] TEN_STEPS = DCNT_W'(TEN_W);

  localparam logic [KR_W-1:0]    KR_RESET  = KR_W'(10000);
  localparam logic [FS_W-1:0]    FS_RESET  = FS_W'(4095);
  localparam logic [COUNT_W-1:0] CNT_RESET = COUNT_W'(500);
  localparam logic [RES_W-1:0]   R_MAX     = {RES_W{1'b1}};
  localparam logic [MULT_W-1:0]  MULT_NEG1 = {MULT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_KNOWN_RES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_CNT = 2'd2;

  // datapath operations
  localparam logic [3:0] OP_WAIT   = 4'd0;
  localparam logic [3:0] OP_MUL    = 4'd1;
  localparam logic [3:0] OP_DIV    = 4'd2;
  localparam logic [3:0] OP_AVG    = 4'd3;
  localparam logic [3:0] OP_RLOAD  = 4'd4;
  localparam logic [3:0] OP_RSAVE  = 4'd5;
  localparam logic [3:0] OP_DECADE = 4'd6;
  localparam logic [3:0] OP_TLOAD  = 4'd7;
  localparam logic [3:0] OP_TSAVE  = 4'd8;
  localparam logic [3:0] OP_EMIT   = 4'd9;

  // jump conditions
  localparam logic [2:0] C_NEVER    = 3'd0;
  localparam logic [2:0] C_DONE     = 3'd1;
  localparam logic [2:0] C_DIV_MORE = 3'd2;
  localparam logic [2:0] C_OVER     = 3'd3;
  localparam logic [2:0] C_GE100    = 3'd4;
  localparam logic [2:0] C_GE10     = 3'd5;
  localparam logic [2:0] C_OUT_BUSY = 3'd6;

  // program steps
  localparam logic [STEP_W-1:0] S_WAIT   = 4'd0;
  localparam logic [STEP_W-1:0] S_MUL    = 4'd1;
  localparam logic [STEP_W-1:0] S_ADIV   = 4'd2;
  localparam logic [STEP_W-1:0] S_AVG    = 4'd3;
  localparam logic [STEP_W-1:0] S_RLOAD  = 4'd4;
  localparam logic [STEP_W-1:0] S_RDIV   = 4'd5;
  localparam logic [STEP_W-1:0] S_RSAVE  = 4'd6;
  localparam logic [STEP_W-1:0] S_DECADE = 4'd7;
  localparam logic [STEP_W-1:0] S_TLOAD  = 4'd8;
  localparam logic [STEP_W-1:0] S_TDIV   = 4'd9;
  localparam logic [STEP_W-1:0] S_TSAVE  = 4'd10;
  localparam logic [STEP_W-1:0] S_EMIT   = 4'd11;

  typedef struct packed {
    logic [3:0]        op;
    logic [2:0]        cond;
    logic [STEP_W-1:0] jump;
    logic [STEP_W-1:0] next;
  } ctrl_word_t;

  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    unique case (step)
      S_WAIT:   w = '{OP_WAIT,   C_DONE,     S_MUL,    S_WAIT};
      S_MUL:    w = '{OP_MUL,    C_NEVER,    S_WAIT,   S_ADIV};
      S_ADIV:   w = '{OP_DIV,    C_DIV_MORE, S_ADIV,   S_AVG};
      S_AVG:    w = '{OP_AVG,    C_NEVER,    S_WAIT,   S_RLOAD};
      S_RLOAD:  w = '{OP_RLOAD,  C_OVER,     S_DECADE, S_RDIV};
      S_RDIV:   w = '{OP_DIV,    C_DIV_MORE, S_RDIV,   S_RSAVE};
      S_RSAVE:  w = '{OP_RSAVE,  C_NEVER,    S_WAIT,   S_DECADE};
      S_DECADE: w = '{OP_DECADE, C_GE100,    S_DECADE, S_TLOAD};
      S_TLOAD:  w = '{OP_TLOAD,  C_GE10,     S_EMIT,   S_TDIV};
      S_TDIV:   w = '{OP_DIV,    C_DIV_MORE, S_TDIV,   S_TSAVE};
      S_TSAVE:  w = '{OP_TSAVE,  C_NEVER,    S_WAIT,   S_EMIT};
      S_EMIT:   w = '{OP_EMIT,   C_OUT_BUSY, S_EMIT,   S_WAIT};
      default:  w = '{OP_WAIT,   C_NEVER,    S_WAIT,   S_WAIT};
    endcase
    return w;
  endfunction

  // floor(v/10) by reciprocal, exact for any 31-bit v
  function automatic logic [RES_W-1:0] div10(input logic [RES_W-1:0] v);
    logic [62:0] p;
    p = 63'(v) * 63'(32'hCCCC_CCCD);
    return RES_W'(p[62:35]);
  endfunction

  // tens digit of a value below 100
  function automatic logic [DIG_W-1:0] tens_of(input logic [TEN_W-1:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    return p[14:11];
  endfunction

endpackage

### rtl/core/ohmmeter_color_band_encoder.sv
// Ohmmeter sample averager, resistance divider and color-band encoder (top level).
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  input    | in_valid / in_ready  | sample
//  output   | out_valid / out_ready| average_code resistance_ohms first_digit
//           |                      | second_digit multiplier band_error overrange
//  config   | cfg_we               | cfg_index cfg_data
//
// A sample that does not close a measurement leaves the program in its wait step; the closing
// sample runs a microcoded program on one bit-per-cycle restoring divider: 12 quotient bits for
// the mean, 31 for the resistance, a decade loop that divides by ten at most 8 times, and 7
// quotient bits for the tenths digit.
// Reset (rst, synchronous) restores register defaults and clears the accumulator.
// A result held in the output register stalls the program only at its last step.
module ohmmeter_color_band_encoder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ocbe_pkg::SAMPLE_BITS-1:0]  sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ocbe_pkg::AVG_W-1:0]        average_code,
  output logic [ocbe_pkg::RES_W-1:0]        resistance_ohms,
  output logic [ocbe_pkg::DIG_W-1:0]        first_digit,
  output logic [ocbe_pkg::DIG_W-1:0]        second_digit,
  output logic signed [ocbe_pkg::MULT_W-1:0] multiplier,
  output logic                              band_error,
  output logic                              overrange,
  input  logic                              cfg_we,
  input  logic [ocbe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ocbe_pkg::CFG_W-1:0]        cfg_data
);
  import ocbe_pkg::*;

  logic [KR_W-1:0]    known_res;
  logic [FS_W-1:0]    full_scale;
  logic [COUNT_W-1:0] sample_count;
  logic [SUM_W-1:0]   sample_sum;
  logic [COUNT_W-1:0] samples_taken;
  logic [STEP_W-1:0]  pc;
  logic [STEP_W-1:0]  pc_next;
  logic [NUM_W-1:0]   num;
  logic [SUM_W-1:0]   span;
  logic [SUM_W-1:0]   den;
  logic               zero_den;
  logic               over;
  logic [SUM_W-1:0]   rem;
  logic [RES_W-1:0]   dlo;
  logic [RES_W-1:0]   quo;
  logic [SUM_W-1:0]   divisor;
  logic [DCNT_W-1:0]  dcnt;
  logic [RES_W-1:0]   res;
  logic [RES_W-1:0]   val;
  logic [MULT_W-1:0]  mult;
  logic [AVG_W-1:0]   avg;

  ctrl_word_t         cw;
  logic               in_fire;
  logic [COUNT_W-1:0] taken_next;
  logic [COUNT_W-1:0] eff_count;
  logic               meas_done;
  logic               over_now;
  logic               out_busy;
  logic               cond_true;
  logic [SUM_W:0]     shifted;
  logic [SUM_W:0]     trial;
  logic [P10_W-1:0]   p10;

  assign cw       = ucode(pc);
  assign in_ready = (pc == S_WAIT);
  assign in_fire  = in_valid && in_ready;
  assign out_busy = out_valid && !out_ready;

  always_comb begin
    eff_count = (sample_count == '0) ? COUNT_W'(1) : sample_count;
    if (eff_count > COUNT_W'(MAX_SAMPLES)) begin
      eff_count = COUNT_W'(MAX_SAMPLES);
    end
  end

  assign taken_next = samples_taken + COUNT_W'(1);
  assign meas_done  = (taken_next == '0) || (taken_next >= eff_count);
  assign over_now   = zero_den || ({{(SUM_W-NUM_HI_W){1'b0}}, num[NUM_W-1:RES_W]} >= den);

  // one restoring-divide step
  assign shifted = {rem, dlo[RES_W-1]};
  assign trial   = shifted - {1'b0, divisor};
  assign p10     = (P10_W'(num) << 3) + (P10_W'(num) << 1);

  always_comb begin
    case (cw.cond)
      C_DONE:     cond_true = in_fire && meas_done;
      C_DIV_MORE: cond_true = (dcnt != DCNT_W'(1));
      C_OVER:     cond_true = over_now;
      C_GE100:    cond_true = (val >= RES_W'(100));
      C_GE10:     cond_true = (val >= RES_W'(10));
      C_OUT_BUSY: cond_true = out_busy;
      default:    cond_true = 1'b0;
    endcase
    pc_next = cond_true ? cw.jump : cw.next;
  end

  // control state, configuration, sample accumulator and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pc            <= S_WAIT;
      known_res     <= KR_RESET;
      full_scale    <= FS_RESET;
      sample_count  <= CNT_RESET;
      sample_sum    <= '0;
      samples_taken <= '0;
      out_valid     <= 1'b0;
    end else begin
      pc <= pc_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KNOWN_RES:  known_res    <= cfg_data[KR_W-1:0];
          REG_FULL_SCALE: full_scale   <= cfg_data[FS_W-1:0];
          REG_SAMPLE_CNT: sample_count <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (cw.op == OP_WAIT && in_fire) begin
        sample_sum    <= sample_sum + SUM_W'(sample);
        samples_taken <= taken_next;
      end
      if (cw.op == OP_EMIT && !out_busy) begin
        out_valid     <= 1'b1;
        sample_sum    <= '0;
        samples_taken <= '0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (cw.op)
      OP_MUL: begin
        num     <= NUM_W'(known_res) * NUM_W'(sample_sum);
        span    <= SUM_W'(samples_taken) * SUM_W'(full_scale);
        mult    <= '0;
        over    <= 1'b0;
        rem     <= SUM_W'(sample_sum[SUM_W-1:AVG_W]);
        dlo     <= {sample_sum[AVG_W-1:0], {(RES_W-AVG_W){1'b0}}};
        divisor <= SUM_W'(samples_taken);
        quo     <= '0;
        dcnt    <= AVG_STEPS;
      end
      OP_DIV: begin
        rem  <= trial[SUM_W] ? shifted[SUM_W-1:0] : trial[SUM_W-1:0];
        quo  <= {quo[RES_W-2:0], ~trial[SUM_W]};
        dlo  <= {dlo[RES_W-2:0], 1'b0};
        dcnt <= dcnt - DCNT_W'(1);
      end
      OP_AVG: begin
        avg      <= quo[AVG_W-1:0];
        zero_den <= (span <= sample_sum);
        den      <= span - sample_sum;
      end
      OP_RLOAD: begin
        if (over_now) begin
          over <= 1'b1;
          res  <= R_MAX;
          val  <= R_MAX;
        end else begin
          rem     <= {{(SUM_W-NUM_HI_W){1'b0}}, num[NUM_W-1:RES_W]};
          dlo     <= num[RES_W-1:0];
          divisor <= den;
          quo     <= '0;
          dcnt    <= RES_STEPS;
        end
      end
      OP_RSAVE: begin
        res <= quo;
        val <= quo;
      end
      OP_DECADE: begin
        if (val >= RES_W'(100)) begin
          val  <= div10(val);
          mult <= mult + MULT_W'(1);
        end
      end
      OP_TLOAD: begin
        // below ten ohms: redo as floor(10*num/den), quotient under 100
        if (val < RES_W'(10)) begin
          rem     <= p10[SUM_W+TEN_W-1:TEN_W];
          dlo     <= {p10[TEN_W-1:0], {(RES_W-TEN_W){1'b0}}};
          divisor <= den;
          quo     <= '0;
          dcnt    <= TEN_STEPS;
          mult    <= MULT_NEG1;
        end
      end
      OP_TSAVE: begin
        val <= RES_W'(quo[TEN_W-1:0]);
      end
      OP_EMIT: begin
        if (!out_busy) begin
          average_code    <= avg;
          resistance_ohms <= res;
          first_digit     <= tens_of(val[TEN_W-1:0]);
          second_digit    <= DIG_W'(val[TEN_W-1:0] -
                                    TEN_W'(tens_of(val[TEN_W-1:0])) * TEN_W'(10));
          multiplier      <= $signed(mult);
          band_error      <= mult[MULT_W-1] || (mult > MULT_W'(9));
          overrange       <= over;
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/core/ocbe_checker.sv
// Port-level checker for the ohmmeter band encoder, bound to the top level.
module ocbe_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [ocbe_pkg::AVG_W-1:0]        average_code,
  input logic [ocbe_pkg::RES_W-1:0]        resistance_ohms,
  input logic [ocbe_pkg::DIG_W-1:0]        first_digit,
  input logic [ocbe_pkg::DIG_W-1:0]        second_digit,
  input logic signed [ocbe_pkg::MULT_W-1:0] multiplier,
  input logic                              band_error,
  input logic                              overrange
);
  import ocbe_pkg::*;

  // a held result keeps its resistance, multiplier and average code
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(resistance_ohms)
      && $stable(multiplier) && $stable(average_code))
    else $error("result changed while stalled");

  a_band_err: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> band_error == (multiplier < 0 || multiplier > 9))
    else $error("band_error disagrees with multiplier");

  a_over_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && overrange |-> resistance_ohms == R_MAX)
    else $error("overrange without saturated resistance");

  a_digits: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> first_digit <= 9 && second_digit <= 9
      && (band_error || first_digit != 0))
    else $error("color digits out of range");

endmodule

bind ohmmeter_color_band_encoder ocbe_checker u_ocbe_checker (.*);
